>>> hdl/urtb_pkg.sv
`timescale 1ns / 1ps

package urtb_pkg;

  // event codes on the input channel
  localparam logic [1:0] KIND_RX_BYTE = 2'd0;
  localparam logic [1:0] KIND_TX_DONE = 2'd1;
  localparam logic [1:0] KIND_PUSH    = 2'd2;
  localparam logic [1:0] KIND_POP     = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RX_DROP  = 2'd1;
  localparam logic [1:0] ST_NO_DATA  = 2'd2;
  localparam logic [1:0] ST_TX_FULL  = 2'd3;

  // request into one ring
  typedef struct packed {
    logic       push;
    logic       pop;
    logic [7:0] wdata;
  } ring_ctrl_t;

  // ring flags now and after the current request, plus the oldest byte
  typedef struct packed {
    logic       empty;
    logic       full;
    logic       empty_nxt;
    logic       full_nxt;
    logic [7:0] head;
  } ring_stat_t;

endpackage

>>> hdl/urtb_ring.sv
`timescale 1ns / 1ps

module urtb_ring
  import urtb_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  ring_ctrl_t ctrl,
  output ring_stat_t stat
);

  localparam int AW = $clog2(DEPTH);

  logic [7:0]    mem_r [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] rp_r, rp_nxt;
  logic [7:0]    head_r;

  // pointer advance, wraps on the power-of-two depth
  assign wp_nxt = ctrl.push ? wp_r + AW'(1) : wp_r;
  assign rp_nxt = ctrl.pop  ? rp_r + AW'(1) : rp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
    end
  end

  // storage write
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem_r[wp_r] <= ctrl.wdata;
    end
  end

  // head prefetch at the next read pointer, bypassing a same-cycle write
  always_ff @(posedge clk) begin
    if (ctrl.push && (wp_r == rp_nxt)) begin
      head_r <= ctrl.wdata;
    end else begin
      head_r <= mem_r[rp_nxt];
    end
  end

  assign stat.empty     = (wp_r == rp_r);
  assign stat.full      = ((wp_r + AW'(1)) == rp_r);
  assign stat.empty_nxt = (wp_nxt == rp_nxt);
  assign stat.full_nxt  = ((wp_nxt + AW'(1)) == rp_nxt);
  assign stat.head      = head_r;

endmodule

>>> hdl/uart_rx_tx_ring_buffers.sv
`timescale 1ns / 1ps

// channel   ports                                         handshake
// input     in_kind, in_data_byte                         start && !busy
// result    out_status, out_read_byte, out_send_valid,    out_valid, one cycle
//           out_send_byte, out_rx_not_empty, out_tx_full
//
// one event per cycle; the strobe is registered from the taken event, so each result
// passes the input register, then the result register
// busy stays low: each ring reads its head from a prefetch register, so no event waits
// synchronous active-low reset empties both rings and clears the kick flag
// the receiver cannot stall; every result is shown for exactly one cycle

module uart_rx_tx_ring_buffers
  import urtb_pkg::*;
#(
  parameter int RX_DEPTH = 16,
  parameter int TX_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_kind,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  output logic [1:0] out_status,
  output logic [7:0] out_read_byte,
  output logic       out_send_valid,
  output logic [7:0] out_send_byte,
  output logic       out_rx_not_empty,
  output logic       out_tx_full
);

  logic       vld_r;
  logic [1:0] kind_r;
  logic [7:0] data_r;

  logic       tx_kicked_r, tx_kicked_nxt;

  ring_ctrl_t rx_ctrl, tx_ctrl;
  ring_stat_t rx_st, tx_st;

  logic [1:0] status_nxt;
  logic [7:0] read_byte_nxt;
  logic       send_valid_nxt;
  logic [7:0] send_byte_nxt;

  logic       out_valid_r;
  logic [1:0] out_status_r;
  logic [7:0] out_read_byte_r;
  logic       out_send_valid_r;
  logic [7:0] out_send_byte_r;
  logic       out_rx_not_empty_r;
  logic       out_tx_full_r;

  assign busy = 1'b0;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= in_kind;
    data_r <= in_data_byte;
  end

  // event decode against the ring flags
  always_comb begin
    rx_ctrl        = '0;
    tx_ctrl        = '0;
    rx_ctrl.wdata  = data_r;
    tx_ctrl.wdata  = data_r;
    tx_kicked_nxt  = tx_kicked_r;
    status_nxt     = ST_OK;
    read_byte_nxt  = 8'd0;
    send_valid_nxt = 1'b0;
    send_byte_nxt  = 8'd0;
    if (vld_r) begin
      case (kind_r)
        KIND_RX_BYTE: begin
          if (rx_st.full) begin
            status_nxt = ST_RX_DROP;
          end else begin
            rx_ctrl.push = 1'b1;
          end
        end
        KIND_TX_DONE: begin
          if (tx_st.empty) begin
            tx_kicked_nxt = 1'b0;
          end else begin
            tx_ctrl.pop    = 1'b1;
            send_valid_nxt = 1'b1;
            send_byte_nxt  = tx_st.head;
          end
        end
        KIND_PUSH: begin
          if (tx_st.full) begin
            status_nxt = ST_TX_FULL;
          end else begin
            tx_ctrl.push = 1'b1;
            if (!tx_kicked_r) begin
              // idle transmitter: hand over the oldest byte, which is this one
              // when the ring was empty
              tx_kicked_nxt  = 1'b1;
              tx_ctrl.pop    = 1'b1;
              send_valid_nxt = 1'b1;
              send_byte_nxt  = tx_st.empty ? data_r : tx_st.head;
            end
          end
        end
        KIND_POP: begin
          if (rx_st.empty) begin
            status_nxt = ST_NO_DATA;
          end else begin
            rx_ctrl.pop   = 1'b1;
            read_byte_nxt = rx_st.head;
          end
        end
        default: begin
          status_nxt = ST_OK;
        end
      endcase
    end
  end

  urtb_ring #(.DEPTH(RX_DEPTH)) u_rx_ring (
    .clk  (clk),
    .rst_n(rst_n),
    .ctrl (rx_ctrl),
    .stat (rx_st)
  );

  urtb_ring #(.DEPTH(TX_DEPTH)) u_tx_ring (
    .clk  (clk),
    .rst_n(rst_n),
    .ctrl (tx_ctrl),
    .stat (tx_st)
  );

  // kick flag and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_kicked_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      tx_kicked_r <= tx_kicked_nxt;
      out_valid_r <= vld_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    out_status_r       <= status_nxt;
    out_read_byte_r    <= read_byte_nxt;
    out_send_valid_r   <= send_valid_nxt;
    out_send_byte_r    <= send_byte_nxt;
    out_rx_not_empty_r <= !rx_st.empty_nxt;
    out_tx_full_r      <= tx_st.full_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_read_byte    = out_read_byte_r;
  assign out_send_valid   = out_send_valid_r;
  assign out_send_byte    = out_send_byte_r;
  assign out_rx_not_empty = out_rx_not_empty_r;
  assign out_tx_full      = out_tx_full_r;

  // an idle transmitter never leaves bytes queued
  a_idle_tx_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !tx_kicked_r |-> tx_st.empty)
    else $error("transmit ring holds bytes while the transmitter is idle");

  // every event taken gives exactly one result
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |=> out_valid_r)
    else $error("event taken without a result");

  // reported flags match the ring state left by that event
  a_rx_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_rx_not_empty_r == !rx_st.empty))
    else $error("receive flag disagrees with ring state");

  a_tx_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_tx_full_r == tx_st.full))
    else $error("transmit flag disagrees with ring state");

  // a failed pop returns no data
  a_no_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == ST_NO_DATA)) |-> (out_read_byte_r == 8'd0))
    else $error("failed pop returned a byte");

endmodule
